FILE: hw/rtl/sabe_pkg.sv
package sabe_pkg;

	localparam int ID_W            = 6;
	localparam int NIDS            = 5;
	localparam int CAP_W           = 40;
	localparam int SIZE_W          = 32;
	localparam int INSTR_W         = 32;
	localparam int CNT_W           = 8;
	localparam int NUM_ENTRIES_DEF = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = 40'd1073741824;
	localparam logic [CNT_W-1:0] CNT_MAX   = 8'd255;

	localparam logic [1:0] OP_DEFINE  = 2'd0;
	localparam logic [1:0] OP_BEGIN   = 2'd1;
	localparam logic [1:0] OP_RELEASE = 2'd2;

	localparam logic [1:0] ACT_NONE  = 2'd0;
	localparam logic [1:0] ACT_EVICT = 2'd1;
	localparam logic [1:0] ACT_LOAD  = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OVERSIZE = 2'd1;
	localparam logic [1:0] ST_NOSPACE  = 2'd2;

	typedef struct packed {
		logic [INSTR_W-1:0] last_use;
		logic [CNT_W-1:0]   use_cnt;
		logic               loaded;
		logic [SIZE_W-1:0]  size;
	} entry_t;

endpackage

FILE: hw/rtl/sabe_table.sv
module sabe_table #(
	parameter int NUM_ENTRIES = sabe_pkg::NUM_ENTRIES_DEF,
	parameter int IW          = $clog2(NUM_ENTRIES)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [IW-1:0]     rd_addr,
	output sabe_pkg::entry_t  rd_data,
	input  logic              we,
	input  logic [IW-1:0]     wr_addr,
	input  sabe_pkg::entry_t  wr_data
);

	sabe_pkg::entry_t mem [NUM_ENTRIES];
	sabe_pkg::entry_t rd_q;
	logic [NUM_ENTRIES-1:0] vld_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[rd_addr];
			if (we) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

FILE: hw/rtl/size_aware_buffer_eviction.sv
// Size-aware buffer eviction controller.
// s_* channel takes one request item a transfer; tdata packs op, instr_number,
// first_id..fifth_id and entry_size from bit 0 up. m_* channel returns result
// items: action, entry_id, status, total_loaded in tdata, tlast on the final
// result of a request. cfg_we/cfg_data write the 40-bit capacity register.
// Entry state (size, loaded flag, use count, last use) lives in one table
// with a registered synchronous read; per-entry valid bits make untouched
// entries read as zero, so no clearing pass is needed after reset.
// Requests are handled one at a time:
//   define / release: read the entry, write it back, then the result.
//   begin: slot reads and checks, the availability scan and its check
//   (only if eviction is needed), update writes, one per slot, then for each
//   eviction a table scan that picks the oldest candidate, and a load pass,
//   one slot a cycle unless a load result waits on a stalled output.
// A stalled output holds the sequencer at its next result; s_tready stays low
// until the last result of the current request is in the output register.
// Reset empties the table, clears the loaded total and sets capacity to 1 GiB.
module size_aware_buffer_eviction #(
	parameter int NUM_ENTRIES = sabe_pkg::NUM_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [39:0] cfg_data,       // capacity
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,        // op, instr_number, first..fifth_id, entry_size
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,        // action, entry_id, status, total_loaded
	output logic        m_tlast
);

	localparam int IW = $clog2(NUM_ENTRIES);
	localparam int CW = IW + 1;
	localparam int NI = sabe_pkg::NIDS;

	typedef enum logic [11:0] {
		S_IDLE = 12'h001,
		S_SRD  = 12'h002,
		S_CHK1 = 12'h004,
		S_SCAN = 12'h008,
		S_CHK2 = 12'h010,
		S_UPD  = 12'h020,
		S_SEL  = 12'h040,
		S_EVW  = 12'h080,
		S_LOAD = 12'h100,
		S_ERD  = 12'h200,
		S_EWR  = 12'h400,
		S_EMIT = 12'h800
	} state_t;

	state_t state_q;

	logic [1:0]  op_q;
	logic [31:0] instr_q;
	logic [31:0] nsize_q;
	logic [NI-1:0][5:0] id_q;
	sabe_pkg::entry_t sl_q [NI];
	logic [2:0]  j_q;
	logic [CW-1:0] sc_q;
	logic [39:0] cap_q, total_q, needed_q, avail_q, freed_q;
	logic [40:0] excess_q;
	logic        must_q, found_q, emitted_q;
	logic [NUM_ENTRIES-1:0] cand_q;
	logic [NI-1:0] lp_q;
	sabe_pkg::entry_t best_q;
	logic [IW-1:0] best_idx_q;
	logic [1:0]  status_q;

	logic        ov_q, ol_q;
	logic [1:0]  oact_q, ost_q;
	logic [5:0]  oid_q;
	logic [39:0] otot_q;

	logic [IW-1:0] rd_addr, wr_addr;
	logic we;
	sabe_pkg::entry_t rd_data, wr_data;

	logic ofree;
	logic [NI-1:0] first;
	sabe_pkg::entry_t upd_w [NI];
	logic [IW-1:0] cap_idx;
	logic named;
	logic [2:0] jr;
	logic [40:0] sum41;
	logic [39:0] freed_n;
	logic [NUM_ENTRIES-1:0] cand_n;
	logic stop;
	sabe_pkg::entry_t ewr_w;
	logic [39:0] ewr_tot;

	function automatic logic [IW-1:0] idx_of(input logic [5:0] id);
		logic [5:0] t;
		t = id - 6'd1;
		return t[IW-1:0];
	endfunction

	function automatic logic [5:0] valid_id(input logic [5:0] id);
		return (id != 6'd0 && 8'(id) <= 8'(NUM_ENTRIES)) ? id : 6'd0;
	endfunction

	sabe_table #(.NUM_ENTRIES(NUM_ENTRIES), .IW(IW)) u_table (
		.clk(clk), .arst_n(arst_n),
		.rd_addr(rd_addr), .rd_data(rd_data),
		.we(we), .wr_addr(wr_addr), .wr_data(wr_data)
	);

	assign ofree    = !ov_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = ov_q;
	assign m_tlast  = ol_q;
	assign m_tdata  = {6'd0, otot_q, ost_q, oid_q, oact_q};

	// per-slot first occurrence and post-update words
	always_comb begin
		logic [2:0] occ;
		logic [8:0] s9;
		for (int j = 0; j < NI; j++) begin
			first[j] = (id_q[j] != 6'd0);
			occ = 3'd0;
			for (int i = 0; i < NI; i++) begin
				if (i < j && id_q[i] == id_q[j]) first[j] = 1'b0;
				if (id_q[i] == id_q[j]) occ = occ + 3'd1;
			end
			s9 = {1'b0, sl_q[j].use_cnt} + 9'(occ);
			upd_w[j].size     = sl_q[j].size;
			upd_w[j].loaded   = sl_q[j].loaded;
			upd_w[j].use_cnt  = s9[8] ? sabe_pkg::CNT_MAX : s9[7:0];
			upd_w[j].last_use = (sl_q[j].last_use < instr_q) ? instr_q : sl_q[j].last_use;
		end
	end

	// scan capture: entry id equals sc_q when its data arrives
	always_comb begin
		logic [CW-1:0] t;
		t = sc_q - CW'(1);
		cap_idx = t[IW-1:0];
		named = 1'b0;
		for (int i = 0; i < NI; i++) begin
			if (8'(id_q[i]) == 8'(sc_q)) named = 1'b1;
		end
	end

	assign jr      = (j_q < 3'(NI)) ? j_q : 3'd0;
	assign sum41   = {1'b0, total_q} + {1'b0, needed_q};
	assign freed_n = freed_q + 40'(best_q.size);
	assign cand_n  = cand_q & ~(NUM_ENTRIES'(1) << best_idx_q);
	assign stop    = ({1'b0, freed_n} > excess_q) || (cand_n == '0);

	always_comb begin
		ewr_w   = rd_data;
		ewr_tot = total_q;
		if (op_q == sabe_pkg::OP_DEFINE) begin
			ewr_w.size = nsize_q;
			if (rd_data.loaded) ewr_tot = total_q - 40'(rd_data.size) + 40'(nsize_q);
		end else if (rd_data.use_cnt != '0) begin
			ewr_w.use_cnt = rd_data.use_cnt - 8'd1;
		end
	end

	always_comb begin
		rd_addr = '0;
		we      = 1'b0;
		wr_addr = idx_of(id_q[jr]);
		wr_data = upd_w[jr];
		case (state_q)
			S_SRD: rd_addr = idx_of(id_q[jr]);
			S_SCAN, S_SEL: rd_addr = sc_q[IW-1:0];
			S_ERD: rd_addr = idx_of(id_q[0]);
			S_UPD: we = (id_q[jr] != 6'd0);
			S_LOAD: begin
				we = lp_q[jr] && ofree;
				wr_data.loaded = 1'b1;
			end
			S_EVW: begin
				we = ofree;
				wr_addr = best_idx_q;
				wr_data = best_q;
				wr_data.loaded = 1'b0;
			end
			S_EWR: begin
				we = 1'b1;
				wr_addr = idx_of(id_q[0]);
				wr_data = ewr_w;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q    <= s_tdata[1:0];
				instr_q <= s_tdata[33:2];
				nsize_q <= s_tdata[95:64];
				for (int i = 0; i < NI; i++) id_q[i] <= valid_id(s_tdata[34+6*i +: 6]);
			end
			S_SRD: if (j_q != 3'd0) sl_q[j_q-3'd1] <= rd_data;
			S_CHK1: excess_q <= sum41 - {1'b0, cap_q};
			S_SEL: if (sc_q != '0 && cand_q[cap_idx] &&
					(!found_q || rd_data.last_use < best_q.last_use)) begin
				best_q     <= rd_data;
				best_idx_q <= cap_idx;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cap_q     <= sabe_pkg::CAP_RESET;
			total_q   <= '0;
			j_q       <= '0;
			sc_q      <= '0;
			needed_q  <= '0;
			avail_q   <= '0;
			freed_q   <= '0;
			must_q    <= 1'b0;
			found_q   <= 1'b0;
			emitted_q <= 1'b0;
			cand_q    <= '0;
			lp_q      <= '0;
			status_q  <= sabe_pkg::ST_OK;
			ov_q      <= 1'b0;
			ol_q      <= 1'b0;
			oact_q    <= sabe_pkg::ACT_NONE;
			ost_q     <= sabe_pkg::ST_OK;
			oid_q     <= '0;
			otot_q    <= '0;
		end else begin
			if (cfg_we) cap_q <= cfg_data;
			if (m_tready) ov_q <= 1'b0;
			case (state_q)
				S_IDLE: if (s_tvalid) begin
					status_q  <= sabe_pkg::ST_OK;
					j_q       <= '0;
					needed_q  <= '0;
					emitted_q <= 1'b0;
					if (s_tdata[1:0] == sabe_pkg::OP_BEGIN) begin
						state_q <= S_SRD;
					end else if ((s_tdata[1:0] == sabe_pkg::OP_DEFINE ||
							s_tdata[1:0] == sabe_pkg::OP_RELEASE) &&
							valid_id(s_tdata[39:34]) != 6'd0) begin
						state_q <= S_ERD;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_SRD: begin
					if (j_q != 3'd0 && first[j_q-3'd1] && !rd_data.loaded)
						needed_q <= needed_q + 40'(rd_data.size);
					if (j_q == 3'(NI)) state_q <= S_CHK1;
					else j_q <= j_q + 3'd1;
				end
				S_CHK1: begin
					sc_q    <= '0;
					avail_q <= '0;
					cand_q  <= '0;
					j_q     <= '0;
					must_q  <= (sum41 >= {1'b0, cap_q});
					if (needed_q > cap_q) begin
						status_q <= sabe_pkg::ST_OVERSIZE;
						state_q  <= S_EMIT;
					end else if (sum41 >= {1'b0, cap_q}) begin
						state_q <= S_SCAN;
					end else begin
						state_q <= S_UPD;
					end
				end
				S_SCAN: begin
					if (sc_q != '0) begin
						cand_q[cap_idx] <= rd_data.loaded && rd_data.use_cnt == '0 && !named;
						if (rd_data.loaded && rd_data.use_cnt == '0 && !named)
							avail_q <= avail_q + 40'(rd_data.size);
					end
					if (sc_q == CW'(NUM_ENTRIES)) state_q <= S_CHK2;
					else sc_q <= sc_q + CW'(1);
				end
				S_CHK2: begin
					if ({1'b0, avail_q} < excess_q) begin
						status_q <= sabe_pkg::ST_NOSPACE;
						state_q  <= S_EMIT;
					end else begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					lp_q    <= first & ~{sl_q[4].loaded, sl_q[3].loaded, sl_q[2].loaded,
						sl_q[1].loaded, sl_q[0].loaded};
					freed_q <= '0;
					sc_q    <= '0;
					found_q <= 1'b0;
					if (j_q == 3'(NI-1)) begin
						j_q     <= '0;
						state_q <= must_q ? S_SEL : S_LOAD;
					end else begin
						j_q <= j_q + 3'd1;
					end
				end
				S_SEL: begin
					if (sc_q == '0 && cand_q == '0) begin
						state_q <= S_LOAD;
					end else begin
						if (sc_q != '0 && cand_q[cap_idx] &&
								(!found_q || rd_data.last_use < best_q.last_use))
							found_q <= 1'b1;
						if (sc_q == CW'(NUM_ENTRIES)) state_q <= S_EVW;
						else sc_q <= sc_q + CW'(1);
					end
				end
				S_EVW: if (ofree) begin
					total_q   <= total_q - 40'(best_q.size);
					freed_q   <= freed_n;
					cand_q    <= cand_n;
					emitted_q <= 1'b1;
					ov_q      <= 1'b1;
					oact_q    <= sabe_pkg::ACT_EVICT;
					oid_q     <= 6'(best_idx_q) + 6'd1;
					ost_q     <= sabe_pkg::ST_OK;
					otot_q    <= total_q - 40'(best_q.size);
					ol_q      <= stop && (lp_q == '0);
					sc_q      <= '0;
					found_q   <= 1'b0;
					state_q   <= stop ? S_LOAD : S_SEL;
				end
				S_LOAD: begin
					if (!lp_q[jr] || ofree) begin
						if (lp_q[jr]) begin
							total_q   <= total_q + 40'(sl_q[jr].size);
							lp_q[jr]  <= 1'b0;
							emitted_q <= 1'b1;
							ov_q      <= 1'b1;
							oact_q    <= sabe_pkg::ACT_LOAD;
							oid_q     <= id_q[jr];
							ost_q     <= sabe_pkg::ST_OK;
							otot_q    <= total_q + 40'(sl_q[jr].size);
							ol_q      <= (lp_q & ~(NI'(1) << jr)) == '0;
						end
						if (j_q == 3'(NI-1)) begin
							state_q <= (emitted_q || lp_q[jr]) ? S_IDLE : S_EMIT;
						end else begin
							j_q <= j_q + 3'd1;
						end
					end
				end
				S_ERD: state_q <= S_EWR;
				S_EWR: begin
					total_q <= ewr_tot;
					state_q <= S_EMIT;
				end
				S_EMIT: if (ofree) begin
					ov_q    <= 1'b1;
					oact_q  <= sabe_pkg::ACT_NONE;
					oid_q   <= '0;
					ost_q   <= status_q;
					otot_q  <= total_q;
					ol_q    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
